>>> sv/stable_pivot_partition_core_macros.svh
// Assertion macros used by the stable pivot partition back end.
`ifndef STABLE_PIVOT_PARTITION_CORE_MACROS_SVH
`define STABLE_PIVOT_PARTITION_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SPP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SPP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spp_pkg.sv
// Types and constants for the stable pivot partition block.
package spp_pkg;

  localparam int VALUE_W = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } spp_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflowed;
  } spp_out_t;

  // What the front decided for one input beat.
  typedef enum logic [1:0] {
    OP_PIVOT = 2'd0,
    OP_LOW   = 2'd1,
    OP_HIGH  = 2'd2,
    OP_DROP  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } spp_op_t;

  // Head of the op queue as seen by the back end.
  typedef struct packed {
    logic    vld;
    spp_op_t op;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_LOAD = 2'd0,
    BK_LOW  = 2'd1,
    BK_PIV  = 2'd2,
    BK_HIGH = 2'd3
  } bk_state_t;

endpackage

>>> sv/spp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/spp_front.sv
// Front end: takes input beats, tracks the pivot and sorts each beat into an op.
module spp_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  spp_pkg::spp_in_t in_data,
  input  logic            q_full,
  output logic            push,
  output spp_pkg::spp_op_t op
);
  import spp_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS);

  logic signed [VALUE_W-1:0] pivot_r, pivot_nxt;
  logic                      have_r, have_nxt;
  logic [CW-1:0]             total_r, total_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    pivot_nxt = pivot_r;
    have_nxt  = have_r;
    total_nxt = total_r;
    op.value  = in_data.value;
    op.last   = in_data.last;
    if (!have_r) begin
      op.kind = OP_PIVOT;
    end else if (total_r == CW'(MAX_ITEMS - 1)) begin
      op.kind = OP_DROP;
    end else if (in_data.value > pivot_r) begin
      op.kind = OP_HIGH;
    end else begin
      op.kind = OP_LOW;
    end
    if (push) begin
      if (op.kind == OP_PIVOT) begin
        pivot_nxt = in_data.value;
        have_nxt  = 1'b1;
        total_nxt = '0;
      end else if (op.kind != OP_DROP) begin
        total_nxt = total_r + CW'(1);
      end
      if (in_data.last) begin
        have_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      total_r <= '0;
    end else begin
      have_r  <= have_nxt;
      total_r <= total_nxt;
    end
    pivot_r <= pivot_nxt;
  end

endmodule

>>> sv/spp_queue.sv
// Two-entry op queue between the front and back ends.
module spp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spp_pkg::spp_op_t push_op,
  input  logic             pop,
  output logic             full,
  output spp_pkg::q_head_t head
);
  import spp_pkg::*;

  spp_op_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && (cnt_r != 2'd0);
  assign head.vld = (cnt_r != 2'd0);
  assign head.op  = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
    if (do_push) begin
      ent_r[wp_r] <= push_op;
    end
  end

endmodule

>>> sv/spp_back.sv
// Back end: applies ops to the stores and plays out the partitioned set.
`include "stable_pivot_partition_core_macros.svh"

module spp_back #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spp_pkg::q_head_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output spp_pkg::spp_out_t out_data
);
  import spp_pkg::*;

  localparam int CW    = $clog2(MAX_ITEMS);
  localparam int DEPTH = MAX_ITEMS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bk_state_t state_r, state_nxt;

  logic [VALUE_W-1:0] pivot_r, pivot_nxt;
  logic [CW-1:0]      low_cnt_r, low_cnt_nxt;
  logic [CW-1:0]      high_cnt_r, high_cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               ovf_r, ovf_nxt;

  // read stage: one element in flight between issue and output buffer
  logic      s1_vld_r, s1_vld_nxt;
  op_kind_t  s1_src_r, s1_src_nxt;
  logic      s1_last_r, s1_last_nxt;
  logic      s1_ovf_r, s1_ovf_nxt;

  // two-entry output buffer
  spp_out_t   ob_data_r [2];
  logic       ob_wp_r, ob_rp_r;
  logic [1:0] ob_cnt_r, ob_cnt_nxt;
  logic       pop_out;
  spp_out_t   ob_in;

  logic               credit_ok;
  logic               load_last;
  logic [CW-1:0]      ld_low_cnt;
  logic               low_we, high_we, low_re, high_re;
  logic [AW-1:0]      low_waddr, high_waddr;
  logic [VALUE_W-1:0] low_rdata, high_rdata;

  assign pop_out   = (ob_cnt_r != 2'd0) && !out_stall;
  assign credit_ok = (({1'b0, ob_cnt_r} + {2'b0, s1_vld_r}) - {2'b0, pop_out}) < 3'd2;
  assign q_pop     = (state_r == BK_LOAD) && q_head.vld;
  assign load_last = q_pop && q_head.op.last;

  always_comb begin
    case (q_head.op.kind)
      OP_PIVOT: ld_low_cnt = '0;
      OP_LOW:   ld_low_cnt = low_cnt_r + CW'(1);
      default:  ld_low_cnt = low_cnt_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_LOAD: begin
        if (load_last) begin
          state_nxt = (ld_low_cnt != '0) ? BK_LOW : BK_PIV;
        end
      end
      BK_LOW: begin
        if (credit_ok && (idx_r == low_cnt_r - CW'(1))) begin
          state_nxt = BK_PIV;
        end
      end
      BK_PIV: begin
        if (credit_ok) begin
          state_nxt = (high_cnt_r == '0) ? BK_LOAD : BK_HIGH;
        end
      end
      BK_HIGH: begin
        if (credit_ok && (idx_r == high_cnt_r - CW'(1))) begin
          state_nxt = BK_LOAD;
        end
      end
      default: state_nxt = BK_LOAD;
    endcase
  end

  // datapath and store control
  always_comb begin
    pivot_nxt    = pivot_r;
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    idx_nxt      = idx_r;
    ovf_nxt      = ovf_r;
    low_we       = 1'b0;
    high_we      = 1'b0;
    low_re       = 1'b0;
    high_re      = 1'b0;
    low_waddr    = low_cnt_r[AW-1:0];
    high_waddr   = high_cnt_r[AW-1:0];
    s1_vld_nxt   = 1'b0;
    s1_src_nxt   = s1_src_r;
    s1_last_nxt  = s1_last_r;
    s1_ovf_nxt   = ovf_r;
    case (state_r)
      BK_LOAD: begin
        if (q_pop) begin
          case (q_head.op.kind)
            OP_PIVOT: begin
              pivot_nxt    = q_head.op.value;
              low_cnt_nxt  = '0;
              high_cnt_nxt = '0;
              ovf_nxt      = 1'b0;
            end
            OP_LOW: begin
              low_we      = 1'b1;
              low_cnt_nxt = low_cnt_r + CW'(1);
            end
            OP_HIGH: begin
              high_we      = 1'b1;
              high_cnt_nxt = high_cnt_r + CW'(1);
            end
            OP_DROP: ovf_nxt = 1'b1;
            default: ovf_nxt = ovf_r;
          endcase
          if (q_head.op.last) begin
            idx_nxt = '0;
          end
        end
      end
      BK_LOW: begin
        if (credit_ok) begin
          low_re      = 1'b1;
          s1_vld_nxt  = 1'b1;
          s1_src_nxt  = OP_LOW;
          s1_last_nxt = 1'b0;
          idx_nxt     = (idx_r == low_cnt_r - CW'(1)) ? '0 : idx_r + CW'(1);
        end
      end
      BK_PIV: begin
        if (credit_ok) begin
          s1_vld_nxt  = 1'b1;
          s1_src_nxt  = OP_PIVOT;
          s1_last_nxt = (high_cnt_r == '0);
          idx_nxt     = '0;
        end
      end
      BK_HIGH: begin
        if (credit_ok) begin
          high_re     = 1'b1;
          s1_vld_nxt  = 1'b1;
          s1_src_nxt  = OP_HIGH;
          s1_last_nxt = (idx_r == high_cnt_r - CW'(1));
          idx_nxt     = s1_last_nxt ? '0 : idx_r + CW'(1);
        end
      end
      default: idx_nxt = '0;
    endcase
  end

  always_comb begin
    case (s1_src_r)
      OP_LOW:  ob_in.value_res = low_rdata;
      OP_HIGH: ob_in.value_res = high_rdata;
      default: ob_in.value_res = pivot_r;
    endcase
    ob_in.last_res   = s1_last_r;
    ob_in.overflowed = s1_ovf_r;
  end

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (s1_vld_r && !pop_out) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (pop_out && !s1_vld_r) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  assign out_valid = (ob_cnt_r != 2'd0);
  assign out_data  = ob_data_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_LOAD;
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
      idx_r      <= '0;
      ovf_r      <= 1'b0;
      s1_vld_r   <= 1'b0;
      ob_wp_r    <= 1'b0;
      ob_rp_r    <= 1'b0;
      ob_cnt_r   <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
      idx_r      <= idx_nxt;
      ovf_r      <= ovf_nxt;
      s1_vld_r   <= s1_vld_nxt;
      ob_cnt_r   <= ob_cnt_nxt;
      if (s1_vld_r) begin
        ob_wp_r <= ~ob_wp_r;
      end
      if (pop_out) begin
        ob_rp_r <= ~ob_rp_r;
      end
    end
    pivot_r   <= pivot_nxt;
    s1_src_r  <= s1_src_nxt;
    s1_last_r <= s1_last_nxt;
    s1_ovf_r  <= s1_ovf_nxt;
    if (s1_vld_r) begin
      ob_data_r[ob_wp_r] <= ob_in;
    end
  end

  spp_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_low_ram (
    .clk   (clk),
    .we    (low_we),
    .waddr (low_waddr),
    .wdata (q_head.op.value),
    .re    (low_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (low_rdata)
  );

  spp_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_high_ram (
    .clk   (clk),
    .we    (high_we),
    .waddr (high_waddr),
    .wdata (q_head.op.value),
    .re    (high_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (high_rdata)
  );

  `SPP_CHECK(a_ob_bound, ob_cnt_r <= 2'd2 && !(s1_vld_r && ob_cnt_r == 2'd2 && !pop_out), "output buffer overrun")
  `SPP_CHECK(a_last_ends, !(s1_vld_r && s1_last_r) || state_r == BK_LOAD, "last result while still emitting")
  `SPP_CHECK(a_cap, ({1'b0, low_cnt_r} + {1'b0, high_cnt_r}) <= (CW+1)'(MAX_ITEMS - 1), "store count beyond capacity")
  `SPP_CHECK(a_low_idx, state_r != BK_LOW || idx_r < low_cnt_r, "low read index out of range")
  `SPP_CHECK_NEXT(a_emit_start, load_last, state_r != BK_LOAD, "final op did not start emission")

endmodule

>>> sv/stable_pivot_partition_core.sv
// Top level of the stable pivot partition block.
//
// Usage: a set of signed values arrives one beat per unstalled cycle on in_valid /
// in_stall / in_data, in_data.last marking the final beat. The first value of
// a set is the pivot. Later values go to a low store (not greater than the
// pivot) or a high store, order kept. At most MAX_ITEMS values per set are
// kept, pivot included; extras are dropped and out_data.overflowed is set on
// every result of that set.
// After the final beat the block sends the low values, the pivot, then the
// high values on out_valid / out_stall / out_data, out_data.last_res on the
// final one. out_valid follows the final beat through the op queue, back-end
// state, read stage and output buffer, later if beats of the set still wait
// in the op queue; then one result per cycle while out_stall is low, set by
// the store RAMs' single read port. While loading, one beat is taken per cycle.
// During emission the two-entry op queue keeps taking beats of the next set
// until full, then in_stall rises. A stalled result holds in a two-entry
// output buffer; reads pause until it drains.
// Reset (synchronous, rst_n low) empties the queue and buffers and returns
// to waiting for a pivot. The stores need no clearing.
module stable_pivot_partition_core #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spp_pkg::spp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spp_pkg::spp_out_t out_data
);
  import spp_pkg::*;

  logic    q_full;
  logic    fe_push;
  spp_op_t fe_op;
  logic    q_pop;
  q_head_t q_head;

  // classify each beat against the pivot of the current set
  spp_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (fe_push),
    .op       (fe_op)
  );

  // decouples loading from the emission burst
  spp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .push_op (fe_op),
    .pop     (q_pop),
    .full    (q_full),
    .head    (q_head)
  );

  // store writes and ordered playback
  spp_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the stable pivot partition core.
`timescale 1ns / 100ps

import spp_pkg::*;

// Tracks the partition of the set in flight and holds the beats owed on the output side.
class partition_scoreboard;
  int capacity;
  logic signed [VALUE_W-1:0] pivot;
  bit have_pivot;
  logic signed [VALUE_W-1:0] low_vals[$];
  logic signed [VALUE_W-1:0] high_vals[$];
  bit dropped;
  spp_out_t owed_q[$];
  int mismatches;
  int results_seen;
  int sets_done;
  int overflow_sets;

  function new(int max_items);
    capacity = max_items;
    have_pivot = 1'b0;
    dropped = 1'b0;
    mismatches = 0;
    results_seen = 0;
    sets_done = 0;
    overflow_sets = 0;
  endfunction

  function void owe_result(logic signed [VALUE_W-1:0] v, logic fin);
    spp_out_t r;
    r.value_res = v;
    r.last_res = fin;
    r.overflowed = dropped;
    owed_q.push_back(r);
  endfunction

  // One accepted input beat.
  function void note_beat(spp_in_t beat);
    if (!have_pivot) begin
      pivot = beat.value;
      have_pivot = 1'b1;
    end else if (low_vals.size() + high_vals.size() >= capacity - 1) begin
      dropped = 1'b1;
    end else if (beat.value > pivot) begin
      high_vals.push_back(beat.value);
    end else begin
      low_vals.push_back(beat.value);
    end
    if (beat.last) begin
      foreach (low_vals[i]) owe_result(low_vals[i], 1'b0);
      owe_result(pivot, high_vals.size() == 0);
      foreach (high_vals[i]) owe_result(high_vals[i], i == high_vals.size() - 1);
      sets_done++;
      if (dropped) overflow_sets++;
      low_vals.delete();
      high_vals.delete();
      have_pivot = 1'b0;
      dropped = 1'b0;
    end
  endfunction

  // One accepted output beat, compared with the oldest owed one.
  function void check_result(spp_out_t got);
    spp_out_t want;
    results_seen++;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with nothing owed: value_res=%0d last_res=%0b overflowed=%0b",
                 got.value_res, got.last_res, got.overflowed);
      return;
    end
    want = owed_q.pop_front();
    if (got.value_res !== want.value_res || got.last_res !== want.last_res ||
        got.overflowed !== want.overflowed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d: value_res %0d/%0d last_res %0b/%0b overflowed %0b/%0b (exp/act)",
                 results_seen, want.value_res, got.value_res, want.last_res, got.last_res,
                 want.overflowed, got.overflowed);
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module testbench;
  localparam int MAX_ITEMS = 64;
  localparam int RANDOM_BEATS = 380;
  localparam int QUIET_FROM = 320;   // no idling on either side past this many random beats

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spp_out_t out_data;

  partition_scoreboard sb;

  // Values of the next set; the driver flags the final one with last.
  logic signed [VALUE_W-1:0] set_vals[$];

  bit quiet = 1'b0;
  int out_stall_pct = 0;
  int stall_left = 0;
  int beats_sent = 0;

  stable_pivot_partition_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Watch both channels at the rising edge; inputs only move on the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_beat(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver back-pressure: stalled bursts of random length, rate set per set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(99) < out_stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(4, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one beat, maybe after an idle burst, and hold it until taken.
  task automatic send_beat(input spp_in_t beat, input int idle_pct);
    int gap;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(5, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Sends set_vals as one set. Idle and stall rates change per set, zero included.
  task automatic send_set();
    spp_in_t beat;
    int idle_pct;
    idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
    out_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
    foreach (set_vals[i]) begin
      beat.value = set_vals[i];
      beat.last = (i == set_vals.size() - 1);
      send_beat(beat, idle_pct);
    end
  endtask

  // Element of a random set: half full range, half at or next to the pivot or at a rail.
  function automatic logic signed [VALUE_W-1:0] pick_value(logic signed [VALUE_W-1:0] piv);
    case ($urandom_range(9))
      5: return piv;
      6: return piv + 16'sd1;
      7: return piv - 16'sd1;
      8: return -16'sd32768;
      9: return 16'sd32767;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  initial begin
    int set_len;
    int random_beats;
    int lap;
    logic signed [VALUE_W-1:0] piv;

    sb = new(MAX_ITEMS);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: lone pivots at both rails and zero.
    set_vals = '{16'sd32767};
    send_set();
    set_vals = '{-16'sd32768};
    send_set();
    set_vals = '{16'sd0};
    send_set();
    // Zero pivot: rails, a tie (goes low), and neighbors on both sides.
    set_vals = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
    send_set();
    // Minimum pivot: only its equal stays low.
    set_vals = '{-16'sd32768, 16'sd5, -16'sd32768, 16'sd32767};
    send_set();
    // Maximum pivot: everything lands low.
    set_vals = '{16'sd32767, -16'sd32768, 16'sd32767, 16'sd100};
    send_set();
    // All later values high: pivot is the first result.
    set_vals = '{-16'sd1, 16'sd0, 16'sd1};
    send_set();

    // Random sets. The first three sit at and past capacity: exactly full,
    // one drop on the final beat, several drops.
    random_beats = 0;
    lap = 0;
    while (random_beats < RANDOM_BEATS) begin
      if (lap == 0) set_len = MAX_ITEMS;
      else if (lap == 1) set_len = MAX_ITEMS + 1;
      else if (lap == 2) set_len = MAX_ITEMS + 6;
      else if ($urandom_range(9) == 0) set_len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS - 4);
      else set_len = $urandom_range(10, 1);
      case ($urandom_range(7))
        0: piv = -16'sd32768;
        1: piv = 16'sd32767;
        default: piv = VALUE_W'($urandom);
      endcase
      set_vals = '{piv};
      for (int k = 1; k < set_len; k++) set_vals.push_back(pick_value(piv));
      quiet = (random_beats >= QUIET_FROM);
      send_set();
      random_beats += set_len;
      lap++;
    end
    in_valid <= 1'b0;

    // Drain: every owed result, then a margin past the emission latency.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d beats in %0d sets (%0d with dropped values); checked %0d results.",
             beats_sent, sb.sets_done, sb.overflow_sets, sb.results_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout: %0d results still owed", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
